>>> sv/att_pkg.sv
// Shared constants and the arctangent table for the accelerometer tilt pipeline.
// No dependencies; accel_tilt_angles and the rotator files refer to it by scoped names.
package att_pkg;

  // square-root steps for the horizontal magnitude (radicand is always 62 bits)
  localparam int HRW    = 62;
  localparam int HSTEPS = HRW / 2;

  // vectoring rotator
  localparam int CSTEPS   = 25;
  localparam int ACC_FRAC = 24;
  localparam int CW       = 35;
  localparam int AW       = 36;

  localparam logic signed [AW-1:0] ACC_180 = 36'sd3019898880;

  // atan(2^-i) in units of 2^-24 degree
  function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] idx);
    logic signed [AW-1:0] v;
    case (idx)
      5'd0:  v = 36'sd754974720;
      5'd1:  v = 36'sd445687602;
      5'd2:  v = 36'sd235489089;
      5'd3:  v = 36'sd119537938;
      5'd4:  v = 36'sd60000934;
      5'd5:  v = 36'sd30029717;
      5'd6:  v = 36'sd15018523;
      5'd7:  v = 36'sd7509720;
      5'd8:  v = 36'sd3754917;
      5'd9:  v = 36'sd1877466;
      5'd10: v = 36'sd938734;
      5'd11: v = 36'sd469367;
      5'd12: v = 36'sd234684;
      5'd13: v = 36'sd117342;
      5'd14: v = 36'sd58671;
      5'd15: v = 36'sd29335;
      5'd16: v = 36'sd14668;
      5'd17: v = 36'sd7334;
      5'd18: v = 36'sd3667;
      5'd19: v = 36'sd1833;
      5'd20: v = 36'sd917;
      5'd21: v = 36'sd458;
      5'd22: v = 36'sd229;
      5'd23: v = 36'sd115;
      5'd24: v = 36'sd57;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/att_if.sv
// Valid/ready channels for accelerometer samples and tilt results.
// Standalone; used by the top level and by whoever drives it.
interface att_in_if #(parameter int SB = 16);
  logic                 valid;
  logic                 ready;
  logic signed [SB-1:0] accel_x;
  logic signed [SB-1:0] accel_y;
  logic signed [SB-1:0] accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface att_out_if #(parameter int SB = 16, parameter int AF = 8);
  logic                   valid;
  logic                   ready;
  logic signed [SB-1:0]   z_out;
  logic        [SB-1:0]   magnitude;
  logic signed [AF+7:0]   pitch;
  logic signed [AF+8:0]   roll;

  modport source (output valid, z_out, magnitude, pitch, roll, input ready);
  modport sink   (input valid, z_out, magnitude, pitch, roll, output ready);
endinterface

>>> sv/accel_tilt_angles.sv
// Accelerometer tilt pipeline: magnitude, pitch and roll from one x/y/z sample.
// Depends on att_pkg, att_if, att_sqrt_step, att_cordic_init, att_cordic_step.
//
// Usage:
//   in_ch  carries one sample per beat (accel_x, accel_y, accel_z, signed).
//   out_ch carries one result per beat: z_out (z passed through), magnitude
//   (rounded sqrt of x^2+y^2+z^2), pitch = atan2(y, sqrt(x^2+z^2)) and
//   roll = atan2(-x, z), both in 2^-ANGLE_FRAC_BITS degree, rounded and
//   saturated to +-90 and +-180 degrees. A zero vector gives angle 0.
// Throughput: one sample per cycle while the output is not stalled. Pipeline from
//   accepted input to the result on out_ch: squares, sums, 31 square-root digit
//   stages, rotator set-up, 25 rotation stages, rounding into the output register.
//   The 31 root digits of the horizontal magnitude set the pipeline depth.
// Stall: the whole pipeline advances only while the output register is empty
//   or being taken; in_ch.ready follows that, so nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits, no result is shown.
module accel_tilt_angles #(
  parameter int SAMPLE_BITS     = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  att_in_if.sink   in_ch,
  att_out_if.source out_ch
);
  localparam int SB   = SAMPLE_BITS;
  localparam int AF   = ANGLE_FRAC_BITS;
  localparam int G    = 31 - SB;
  localparam int HRW  = att_pkg::HRW;
  localparam int HN   = att_pkg::HSTEPS;
  localparam int MRW  = 2 * SB;
  localparam int CW   = att_pkg::CW;
  localparam int AW   = att_pkg::AW;
  localparam int CS   = att_pkg::CSTEPS;
  localparam int SH   = att_pkg::ACC_FRAC - AF;
  localparam logic signed [AW-1:0] RND    = AW'(1) <<< (SH - 1);
  localparam logic signed [AW-1:0] LIM_P  = AW'(90) <<< AF;
  localparam logic signed [AW-1:0] LIM_R  = AW'(180) <<< AF;

  logic en;
  logic out_v_r;

  // advance everything when the output slot is free or being drained
  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---- stage: squares
  logic                 q_v_r;
  logic signed [SB-1:0] q_x_r, q_y_r, q_z_r;
  logic [2*SB-1:0]      q_xx_r, q_yy_r, q_zz_r;
  logic signed [2*SB-1:0] px, py, pz;

  assign px = in_ch.accel_x * in_ch.accel_x;
  assign py = in_ch.accel_y * in_ch.accel_y;
  assign pz = in_ch.accel_z * in_ch.accel_z;

  // capture squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else if (en) begin
      q_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_x_r  <= in_ch.accel_x;
      q_y_r  <= in_ch.accel_y;
      q_z_r  <= in_ch.accel_z;
      q_xx_r <= px;
      q_yy_r <= py;
      q_zz_r <= pz;
    end
  end

  // ---- square-root stages, index 0 loaded with the sums
  logic                 s_v_r    [HN+1];
  logic signed [SB-1:0] s_x_r    [HN+1];
  logic signed [SB-1:0] s_y_r    [HN+1];
  logic signed [SB-1:0] s_z_r    [HN+1];
  logic [HRW-1:0]       s_hrad_r [HN+1];
  logic [HN+1:0]        s_hrem_r [HN+1];
  logic [HN-1:0]        s_hroot_r[HN+1];
  logic [MRW-1:0]       s_mrad_r [HN+1];
  logic [SB+1:0]        s_mrem_r [HN+1];
  logic [SB-1:0]        s_mroot_r[HN+1];
  logic [2*SB-1:0]      sxz;

  assign sxz = q_xx_r + q_zz_r;

  // form sums of squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r[0] <= 1'b0;
    end else if (en) begin
      s_v_r[0] <= q_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_x_r[0]     <= q_x_r;
      s_y_r[0]     <= q_y_r;
      s_z_r[0]     <= q_z_r;
      s_hrad_r[0]  <= HRW'(sxz) << (2 * G);
      s_hrem_r[0]  <= '0;
      s_hroot_r[0] <= '0;
      s_mrad_r[0]  <= sxz + q_yy_r;
      s_mrem_r[0]  <= '0;
      s_mroot_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < HN; k++) begin : g_sqrt
    logic [HRW-1:0] hrad;
    logic [HN+1:0]  hrem;
    logic [HN-1:0]  hroot;
    logic [MRW-1:0] mrad;
    logic [SB+1:0]  mrem;
    logic [SB-1:0]  mroot;

    att_sqrt_step #(.RW(HRW)) u_hstep (
      .rad_i (s_hrad_r[k]), .rem_i (s_hrem_r[k]), .root_i (s_hroot_r[k]),
      .rad_o (hrad),        .rem_o (hrem),        .root_o (hroot)
    );

    if (k < SB) begin : g_mag
      att_sqrt_step #(.RW(MRW)) u_mstep (
        .rad_i (s_mrad_r[k]), .rem_i (s_mrem_r[k]), .root_i (s_mroot_r[k]),
        .rad_o (mrad),        .rem_o (mrem),        .root_o (mroot)
      );
    end else begin : g_hold
      assign mrad  = s_mrad_r[k];
      assign mrem  = s_mrem_r[k];
      assign mroot = s_mroot_r[k];
    end

    // advance one root digit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_v_r[k+1] <= 1'b0;
      end else if (en) begin
        s_v_r[k+1] <= s_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_x_r[k+1]     <= s_x_r[k];
        s_y_r[k+1]     <= s_y_r[k];
        s_z_r[k+1]     <= s_z_r[k];
        s_hrad_r[k+1]  <= hrad;
        s_hrem_r[k+1]  <= hrem;
        s_hroot_r[k+1] <= hroot;
        s_mrad_r[k+1]  <= mrad;
        s_mrem_r[k+1]  <= mrem;
        s_mroot_r[k+1] <= mroot;
      end
    end
  end

  // ---- rotator set-up and magnitude rounding
  logic signed [CW-1:0] px0, py0, rx0, ry0;
  logic signed [CW-1:0] px1, py1, rx1, ry1;
  logic signed [AW-1:0] pa1, ra1;
  logic                 pz1, rz1;
  logic [SB-1:0]        mag_rnd;

  assign px0 = CW'(s_hroot_r[HN]);
  assign py0 = CW'(s_y_r[HN]) <<< G;
  assign rx0 = CW'(s_z_r[HN]) <<< G;
  assign ry0 = -(CW'(s_x_r[HN]) <<< G);
  assign mag_rnd = (s_mrem_r[HN] > (SB+2)'(s_mroot_r[HN])) ? s_mroot_r[HN] + 1'b1
                                                          : s_mroot_r[HN];

  att_cordic_init u_pinit (.x_i(px0), .y_i(py0), .x_o(px1), .y_o(py1),
                           .acc_o(pa1), .zero_o(pz1));
  att_cordic_init u_rinit (.x_i(rx0), .y_i(ry0), .x_o(rx1), .y_o(ry1),
                           .acc_o(ra1), .zero_o(rz1));

  logic                 c_v_r   [CS+1];
  logic signed [SB-1:0] c_z_r   [CS+1];
  logic [SB-1:0]        c_mag_r [CS+1];
  logic                 c_pz_r  [CS+1];
  logic                 c_rz_r  [CS+1];
  logic signed [CW-1:0] c_px_r  [CS+1];
  logic signed [CW-1:0] c_py_r  [CS+1];
  logic signed [AW-1:0] c_pa_r  [CS+1];
  logic signed [CW-1:0] c_rx_r  [CS+1];
  logic signed [CW-1:0] c_ry_r  [CS+1];
  logic signed [AW-1:0] c_ra_r  [CS+1];

  // load the rotators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r[0] <= 1'b0;
    end else if (en) begin
      c_v_r[0] <= s_v_r[HN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_z_r[0]   <= s_z_r[HN];
      c_mag_r[0] <= mag_rnd;
      c_pz_r[0]  <= pz1;
      c_rz_r[0]  <= rz1;
      c_px_r[0]  <= px1;
      c_py_r[0]  <= py1;
      c_pa_r[0]  <= pa1;
      c_rx_r[0]  <= rx1;
      c_ry_r[0]  <= ry1;
      c_ra_r[0]  <= ra1;
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_rot
    logic signed [CW-1:0] pxn, pyn, rxn, ryn;
    logic signed [AW-1:0] pan, ran;

    att_cordic_step #(.STEP(i)) u_pstep (
      .x_i(c_px_r[i]), .y_i(c_py_r[i]), .acc_i(c_pa_r[i]),
      .x_o(pxn), .y_o(pyn), .acc_o(pan)
    );
    att_cordic_step #(.STEP(i)) u_rstep (
      .x_i(c_rx_r[i]), .y_i(c_ry_r[i]), .acc_i(c_ra_r[i]),
      .x_o(rxn), .y_o(ryn), .acc_o(ran)
    );

    // advance one rotation
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_v_r[i+1] <= 1'b0;
      end else if (en) begin
        c_v_r[i+1] <= c_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_z_r[i+1]   <= c_z_r[i];
        c_mag_r[i+1] <= c_mag_r[i];
        c_pz_r[i+1]  <= c_pz_r[i];
        c_rz_r[i+1]  <= c_rz_r[i];
        c_px_r[i+1]  <= pxn;
        c_py_r[i+1]  <= pyn;
        c_pa_r[i+1]  <= pan;
        c_rx_r[i+1]  <= rxn;
        c_ry_r[i+1]  <= ryn;
        c_ra_r[i+1]  <= ran;
      end
    end
  end

  // ---- round, saturate and register the result
  logic signed [AW-1:0] p_rnd, r_rnd, p_sat, r_sat;
  logic signed [AF+7:0] pitch_nxt;
  logic signed [AF+8:0] roll_nxt;

  always_comb begin
    p_rnd = (c_pa_r[CS] + RND) >>> SH;
    r_rnd = (c_ra_r[CS] + RND) >>> SH;
    p_sat = (p_rnd > LIM_P) ? LIM_P : ((p_rnd < -LIM_P) ? -LIM_P : p_rnd);
    r_sat = (r_rnd > LIM_R) ? LIM_R : ((r_rnd < -LIM_R) ? -LIM_R : r_rnd);
    pitch_nxt = c_pz_r[CS] ? '0 : (AF+8)'(p_sat);
    roll_nxt  = c_rz_r[CS] ? '0 : (AF+9)'(r_sat);
  end

  logic signed [SB-1:0] z_out_r;
  logic [SB-1:0]        mag_r;
  logic signed [AF+7:0] pitch_r;
  logic signed [AF+8:0] roll_r;

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= c_v_r[CS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_out_r <= c_z_r[CS];
      mag_r   <= c_mag_r[CS];
      pitch_r <= pitch_nxt;
      roll_r  <= roll_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.z_out     = z_out_r;
  assign out_ch.magnitude = mag_r;
  assign out_ch.pitch     = pitch_r;
  assign out_ch.roll      = roll_r;
endmodule

>>> sv/att_sqrt_step.sv
// One digit-by-digit square-root step: pulls two radicand bits, yields one root bit.
// No package dependencies.
module att_sqrt_step #(
  parameter int RW = 62
) (
  input  logic [RW-1:0]   rad_i,
  input  logic [RW/2+1:0] rem_i,
  input  logic [RW/2-1:0] root_i,
  output logic [RW-1:0]   rad_o,
  output logic [RW/2+1:0] rem_o,
  output logic [RW/2-1:0] root_o
);
  localparam int N = RW / 2;

  logic [N+3:0] r2;
  logic [N+3:0] trial;

  // try root*4+1 against the shifted remainder
  always_comb begin
    r2    = {rem_i, rad_i[RW-1 -: 2]};
    trial = (N+4)'({root_i, 2'b01});
    rad_o = rad_i << 2;
    if (r2 >= trial) begin
      rem_o  = (N+2)'(r2 - trial);
      root_o = {root_i[N-2:0], 1'b1};
    end else begin
      rem_o  = (N+2)'(r2);
      root_o = {root_i[N-2:0], 1'b0};
    end
  end
endmodule

>>> sv/att_cordic_init.sv
// Rotator set-up: fold the left half-plane onto the right and flag a zero vector.
// Uses att_pkg for widths and the half-turn constant.
module att_cordic_init (
  input  logic signed [att_pkg::CW-1:0] x_i,
  input  logic signed [att_pkg::CW-1:0] y_i,
  output logic signed [att_pkg::CW-1:0] x_o,
  output logic signed [att_pkg::CW-1:0] y_o,
  output logic signed [att_pkg::AW-1:0] acc_o,
  output logic                          zero_o
);
  always_comb begin
    zero_o = (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      x_o   = -x_i;
      y_o   = -y_i;
      acc_o = (y_i >= 0) ? att_pkg::ACC_180 : -att_pkg::ACC_180;
    end else begin
      x_o   = x_i;
      y_o   = y_i;
      acc_o = '0;
    end
  end
endmodule

>>> sv/att_cordic_step.sv
// One vectoring rotation: drive y toward zero and accumulate the angle.
// Uses att_pkg for widths and the arctangent table.
module att_cordic_step #(
  parameter int STEP = 0
) (
  input  logic signed [att_pkg::CW-1:0] x_i,
  input  logic signed [att_pkg::CW-1:0] y_i,
  input  logic signed [att_pkg::AW-1:0] acc_i,
  output logic signed [att_pkg::CW-1:0] x_o,
  output logic signed [att_pkg::CW-1:0] y_o,
  output logic signed [att_pkg::AW-1:0] acc_o
);
  logic signed [att_pkg::CW-1:0] dx;
  logic signed [att_pkg::CW-1:0] dy;
  logic signed [att_pkg::AW-1:0] ang;

  always_comb begin
    dx  = y_i >>> STEP;
    dy  = x_i >>> STEP;
    ang = att_pkg::atan_tab(5'(STEP));
    if (y_i > 0) begin
      x_o   = x_i + dx;
      y_o   = y_i - dy;
      acc_o = acc_i + ang;
    end else begin
      x_o   = x_i - dx;
      y_o   = y_i + dy;
      acc_o = acc_i - ang;
    end
  end
endmodule

>>> sv/att_checker.sv
// Port-level checks for accel_tilt_angles, attached with a bind.
// Depends only on the top level's ports.
module att_checker #(
  parameter int SB = 16,
  parameter int AF = 8
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [SB-1:0] z_out,
  input logic [SB-1:0]        magnitude,
  input logic signed [AF+7:0] pitch,
  input logic signed [AF+8:0] roll
);
  localparam logic signed [AF+8:0] LIM_P = (AF+9)'(90) <<< AF;
  localparam logic signed [AF+9:0] LIM_R = (AF+10)'(180) <<< AF;

  logic [SB:0] z_abs;
  assign z_abs = (z_out < 0) ? (SB+1)'(-(SB+1)'(z_out)) : (SB+1)'(z_out);

  // stalled result stays valid with magnitude and pitch held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(pitch))
    else $error("result changed under stall");

  // input side opens exactly when the output slot can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output slot");

  // magnitude never below |z|
  a_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (SB+1)'(magnitude) >= z_abs)
    else $error("magnitude smaller than |z|");

  // angles stay within their ranges
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (AF+9)'(pitch) <= LIM_P && (AF+9)'(pitch) >= -LIM_P &&
                  (AF+10)'(roll) <= LIM_R && (AF+10)'(roll) >= -LIM_R)
    else $error("angle out of range");

  // nothing shown right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind accel_tilt_angles att_checker #(.SB(SAMPLE_BITS), .AF(ANGLE_FRAC_BITS)) u_att_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .z_out     (out_ch.z_out),
  .magnitude (out_ch.magnitude),
  .pitch     (out_ch.pitch),
  .roll      (out_ch.roll)
);

>>> tb/tilt_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the tilt pipeline: predicts z, magnitude, pitch and roll per sample.
// Depends on att_if (att_in_if, att_out_if); watches both channels passively.
module tilt_checker (
  input  logic clk,
  input  logic rst_n,
  att_in_if    in_bus,
  att_out_if   out_bus,
  output int   fail_count,
  output int   pending,
  output int   seen_results
);

  typedef struct packed {
    logic signed [15:0] z_out;
    logic        [15:0] magnitude;
    logic signed [15:0] pitch;
    logic signed [16:0] roll;
  } tilt_result_t;

  localparam int GUARD = 15;
  localparam int STEPS = 25;
  localparam longint ARC_TAB [STEPS] = '{
    754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57};

  tilt_result_t expected_q[$];

  // bitwise integer square root, floor
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // vectoring rotation, angle in 1/256 degree, saturated to +-lim_deg
  function automatic longint arc_angle(longint xv, longint yv, longint lim_deg);
    longint acc, dx, dy, r, lim;
    acc = 0;
    lim = lim_deg * 256;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      acc = (yv >= 0) ? 180 * (64'sd1 <<< 24) : -(180 * (64'sd1 <<< 24));
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv > 0) begin
        xv = xv + dx;
        yv = yv - dy;
        acc = acc + ARC_TAB[i];
      end else begin
        xv = xv - dx;
        yv = yv + dy;
        acc = acc - ARC_TAB[i];
      end
    end
    r = (acc + (64'sd1 <<< 15)) >>> 16;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic tilt_result_t predict_tilt(logic signed [15:0] ax,
                                                logic signed [15:0] ay,
                                                logic signed [15:0] az);
    tilt_result_t res;
    longint x, y, z, hor;
    longint unsigned sxz, sum, mag;
    x = longint'(ax);
    y = longint'(ay);
    z = longint'(az);
    sxz = x * x + z * z;
    sum = sxz + y * y;
    mag = isqrt(sum);
    if (sum - mag * mag > mag) mag = mag + 1;
    hor = isqrt(sxz << (2 * GUARD));
    res.z_out     = az;
    res.magnitude = mag[15:0];
    res.pitch     = 16'(arc_angle(hor, y <<< GUARD, 90));
    res.roll      = 17'(arc_angle(z <<< GUARD, (-x) <<< GUARD, 180));
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("tilt_checker: %s mismatch at %0t: got %0d expected %0d",
             what, $realtime, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    seen_results = 0;
    pending = 0;
  end

  // capture accepted samples and compare accepted results
  always @(posedge clk) begin
    tilt_result_t want;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        expected_q.push_back(predict_tilt(in_bus.accel_x, in_bus.accel_y, in_bus.accel_z));
      if (out_bus.valid && out_bus.ready) begin
        seen_results++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_bus.z_out !== want.z_out)
            report_mismatch("z_out", longint'(out_bus.z_out), longint'(want.z_out));
          if (out_bus.magnitude !== want.magnitude)
            report_mismatch("magnitude", longint'(out_bus.magnitude),
                            longint'(want.magnitude));
          if (out_bus.pitch !== want.pitch)
            report_mismatch("pitch", longint'(out_bus.pitch), longint'(want.pitch));
          if (out_bus.roll !== want.roll)
            report_mismatch("roll", longint'(out_bus.roll), longint'(want.roll));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> tb/tb_accel_tilt_angles.sv
`timescale 1ns / 1ps
// Top of the tilt pipeline testbench: clock, reset, sample stimulus and verdict.
// Depends on att_if, accel_tilt_angles and tilt_checker.
module tb_accel_tilt_angles;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 2000;

  logic clk;
  logic rst_n;
  int   fail_count, pending, seen_results;
  int   cycle_count;
  int   src_idle_pct, snk_idle_pct;
  int   sent;

  att_in_if  #(.SB(16))          in_bus ();
  att_out_if #(.SB(16), .AF(8))  out_bus ();

  accel_tilt_angles DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  tilt_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_bus       (in_bus),
    .out_bus      (out_bus),
    .fail_count   (fail_count),
    .pending      (pending),
    .seen_results (seen_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // stall the result side at random
  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // send one beat, idling first at random
  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.accel_x <= ax;
    in_bus.accel_y <= ay;
    in_bus.accel_z <= az;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic signed [15:0] rand_axis(int kind);
    case (kind)
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(8192)) - 4096);
      2: return ($urandom_range(1) == 0) ? 16'sd0 : 16'($signed($urandom_range(64)) - 32);
      default: return ($urandom_range(1) == 0) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  task automatic send_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40)
      send_sample(rand_axis(0), rand_axis(0), rand_axis(0));
    else if (pick < 75)
      send_sample(rand_axis(1), rand_axis(1), rand_axis(1) + 16'sd2048);
    else if (pick < 93)
      send_sample(rand_axis($urandom_range(2)), rand_axis($urandom_range(2)),
                  rand_axis($urandom_range(2)));
    else
      send_sample(rand_axis($urandom_range(3)), rand_axis($urandom_range(3)),
                  rand_axis($urandom_range(3)));
  endtask

  initial begin
    cycle_count    = 0;
    sent           = 0;
    src_idle_pct   = 36;
    snk_idle_pct   = 78;
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.accel_x = '0;
    in_bus.accel_y = '0;
    in_bus.accel_z = '0;
    out_bus.ready  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero vector, axes, extremes, negated minimum, roll near +-180
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd2048);
    send_sample(16'sd0, 16'sd0, -16'sd2048);
    send_sample(16'sd0, 16'sd2048, 16'sd0);
    send_sample(16'sd0, -16'sd2048, 16'sd0);
    send_sample(16'sd2048, 16'sd0, 16'sd0);
    send_sample(-16'sd2048, 16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sd0, 16'sd0);
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(16'sd0, 16'sh7fff, 16'sd0);
    send_sample(16'sd0, 16'sh8000, 16'sd0);
    send_sample(16'sd1, 16'sd0, -16'sd32768);
    send_sample(-16'sd1, 16'sd0, -16'sd32768);
    send_sample(16'sd0, 16'sd0, 16'sh8000);
    send_sample(16'sd0, 16'sd1, 16'sd0);
    send_sample(16'sd1, 16'sd1, 16'sd1);
    send_sample(-16'sd1, -16'sd1, -16'sd1);
    send_sample(16'sd1448, 16'sd1448, 16'sd0);
    send_sample(-16'sd1448, 16'sd0, -16'sd1448);

    // random, three idling regimes
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 78 : 0;
      snk_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 36 : 0;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_random();
    end
    in_bus.valid <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d samples sent, %0d results checked over three stall regimes",
             sent, seen_results);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", fail_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/att_pkg.sv
sv/att_if.sv
sv/att_sqrt_step.sv
sv/att_cordic_init.sv
sv/att_cordic_step.sv
sv/accel_tilt_angles.sv
sv/att_checker.sv
tb/tilt_checker.sv
tb/tb_accel_tilt_angles.sv
